[rtl/read_vs_strain_mismatch_counter_assert.svh]
// Assertion helpers for the top-level RTL file; they expect clk and rst_n in scope.
`ifndef READ_VS_STRAIN_MISMATCH_COUNTER_ASSERT_SVH
`define READ_VS_STRAIN_MISMATCH_COUNTER_ASSERT_SVH

// Same-cycle implication.
`define RSMC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RSMC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rsmc_pkg.sv]
package rsmc_pkg;

  localparam int NUM_STRAINS_DEF = 16;
  localparam int MSA_COLS_DEF    = 32768;
  localparam int REF_LEN_DEF     = 32768;

  // Request kinds
  localparam logic [1:0] ACT_STRAIN = 2'd0;
  localparam logic [1:0] ACT_MAP    = 2'd1;
  localparam logic [1:0] ACT_START  = 2'd2;
  localparam logic [1:0] ACT_BASE   = 2'd3;

  // Base codes held in the column store
  localparam logic [2:0] CODE_A   = 3'd0;
  localparam logic [2:0] CODE_C   = 3'd1;
  localparam logic [2:0] CODE_G   = 3'd2;
  localparam logic [2:0] CODE_T   = 3'd3;
  localparam logic [2:0] CODE_GAP = 3'd4;
  localparam logic [2:0] CODE_UNK = 3'd5;

  localparam logic [7:0] CHAR_A_UP = 8'h41;
  localparam logic [7:0] CHAR_C_UP = 8'h43;
  localparam logic [7:0] CHAR_G_UP = 8'h47;
  localparam logic [7:0] CHAR_T_UP = 8'h54;
  localparam logic [7:0] CHAR_A_LO = 8'h61;
  localparam logic [7:0] CHAR_C_LO = 8'h63;
  localparam logic [7:0] CHAR_G_LO = 8'h67;
  localparam logic [7:0] CHAR_T_LO = 8'h74;
  localparam logic [7:0] CHAR_GAP  = 8'h2D;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Configuration port
  localparam int         CFG_AW        = 3;
  localparam int         CFG_IDX_LSB   = 2;
  localparam logic       REG_STRAINS   = 1'b0;
  localparam logic [4:0] STRAINS_RESET = 5'd16;

  typedef struct packed {
    logic       start;
    logic       base;
    logic       hit;
    logic       last;
    logic [1:0] code;
  } rsmc_tally_ctl_t;

  function automatic logic [2:0] base_code(input logic [7:0] ch);
    logic [2:0] code;
    case (ch)
      CHAR_A_UP, CHAR_A_LO: code = CODE_A;
      CHAR_C_UP, CHAR_C_LO: code = CODE_C;
      CHAR_G_UP, CHAR_G_LO: code = CODE_G;
      CHAR_T_UP, CHAR_T_LO: code = CODE_T;
      CHAR_GAP:             code = CODE_GAP;
      default:              code = CODE_UNK;
    endcase
    return code;
  endfunction

endpackage

[rtl/rsmc_if.sv]
interface rsmc_in_if;
  import rsmc_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [3:0]  strain_slot;
  logic [14:0] column;
  logic [14:0] ref_pos;
  logic [15:0] read_start;
  logic [7:0]  base_char;
  logic        last_base;

  modport source(output valid, action, strain_slot, column, ref_pos, read_start,
                 base_char, last_base, input ready);
  modport sink(input valid, action, strain_slot, column, ref_pos, read_start,
               base_char, last_base, output ready);
endinterface

interface rsmc_out_if;
  import rsmc_pkg::*;
  logic        valid;
  logic        ready;
  logic [3:0]  slot_out;
  logic [15:0] mismatches;
  logic        last_slot;

  modport source(output valid, slot_out, mismatches, last_slot, input ready);
  modport sink(input valid, slot_out, mismatches, last_slot, output ready);
endinterface

[rtl/rsmc_posmap.sv]
module rsmc_posmap #(
  parameter int REF_LEN  = rsmc_pkg::REF_LEN_DEF,
  parameter int MSA_COLS = rsmc_pkg::MSA_COLS_DEF,
  parameter int MAP_AW   = $clog2(REF_LEN),
  parameter int COL_AW   = $clog2(MSA_COLS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              we,
  input  logic [MAP_AW-1:0] waddr,
  input  logic [COL_AW-1:0] wcol,
  input  logic              re,
  input  logic [MAP_AW-1:0] raddr,
  output logic              rd_valid,
  output logic [COL_AW-1:0] rd_col,
  output logic              clear_busy
);
  import rsmc_pkg::*;

  logic [COL_AW:0]   mem [REF_LEN];
  logic [COL_AW:0]   rd_r;
  logic              clear_busy_r;
  logic [MAP_AW-1:0] clr_idx_r;

  // Sweep every entry to unmapped after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_busy_r <= 1'b1;
      clr_idx_r    <= '0;
    end else if (clear_busy_r) begin
      if (clr_idx_r == MAP_AW'(REF_LEN - 1)) begin
        clear_busy_r <= 1'b0;
      end
      clr_idx_r <= clr_idx_r + MAP_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (clear_busy_r) begin
      mem[clr_idx_r] <= '0;
    end else if (we) begin
      mem[waddr] <= {1'b1, wcol};
    end
    if (re) begin
      rd_r <= mem[raddr];
    end
  end

  assign rd_valid   = rd_r[COL_AW];
  assign rd_col     = rd_r[COL_AW-1:0];
  assign clear_busy = clear_busy_r;

endmodule

[rtl/rsmc_colstore.sv]
module rsmc_colstore #(
  parameter int NUM_STRAINS = rsmc_pkg::NUM_STRAINS_DEF,
  parameter int MSA_COLS    = rsmc_pkg::MSA_COLS_DEF,
  parameter int COL_AW      = $clog2(MSA_COLS)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [COL_AW-1:0]        waddr,
  input  logic [3:0]               wslot,
  input  logic [2:0]               wcode,
  input  logic                     re,
  input  logic [COL_AW-1:0]        raddr,
  output logic [3*NUM_STRAINS-1:0] rdata
);
  import rsmc_pkg::*;

  logic [3*NUM_STRAINS-1:0] mem [MSA_COLS];
  logic [3*NUM_STRAINS-1:0] rd_r;

  // Per-strain write enables, read returns the whole column.
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_STRAINS; i++) begin
      if (we && (32'(wslot) == i)) begin
        mem[waddr][3*i +: 3] <= wcode;
      end
    end
    if (re) begin
      rd_r <= mem[raddr];
    end
  end

  assign rdata = rd_r;

endmodule

[rtl/rsmc_tally.sv]
module rsmc_tally #(
  parameter int NUM_STRAINS = rsmc_pkg::NUM_STRAINS_DEF,
  parameter int N_W         = $clog2(NUM_STRAINS + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rsmc_pkg::rsmc_tally_ctl_t ctl,
  input  logic [3*NUM_STRAINS-1:0]  col_data,
  input  logic [N_W-1:0]            n_active,
  output logic                      snap_load,
  output logic [16*NUM_STRAINS-1:0] snap
);
  import rsmc_pkg::*;

  logic [15:0] cnt_r   [NUM_STRAINS];
  logic [15:0] cnt_upd [NUM_STRAINS];

  always_comb begin
    logic [2:0] s;
    logic       miss;
    for (int i = 0; i < NUM_STRAINS; i++) begin
      s    = col_data[3*i +: 3];
      miss = ctl.base && ctl.hit && (i < 32'(n_active)) &&
             (s != {1'b0, ctl.code}) && (s != CODE_GAP);
      // Hold at the ceiling.
      cnt_upd[i] = (miss && (cnt_r[i] != COUNT_MAX)) ? cnt_r[i] + 16'd1 : cnt_r[i];
      snap[16*i +: 16] = cnt_upd[i];
    end
  end

  assign snap_load = ctl.base && ctl.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STRAINS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_STRAINS; i++) begin
        if (ctl.start || snap_load) begin
          cnt_r[i] <= '0;
        end else begin
          cnt_r[i] <= cnt_upd[i];
        end
      end
    end
  end

endmodule

[rtl/rsmc_emit.sv]
module rsmc_emit #(
  parameter int NUM_STRAINS = rsmc_pkg::NUM_STRAINS_DEF,
  parameter int N_W         = $clog2(NUM_STRAINS + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      snap_load,
  input  logic [16*NUM_STRAINS-1:0] snap,
  input  logic [N_W-1:0]            n_active,
  output logic                      busy,
  rsmc_out_if.source                out_ch
);
  import rsmc_pkg::*;

  logic [15:0]    sh_r [NUM_STRAINS];
  logic [N_W-1:0] idx_r;
  logic [N_W-1:0] n_r;
  logic           busy_r;
  logic           is_last;
  logic           out_acc;

  assign is_last = (idx_r == n_r - N_W'(1));
  assign out_acc = busy_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (snap_load) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (out_acc) begin
      if (is_last) begin
        busy_r <= 1'b0;
      end
      idx_r <= idx_r + N_W'(1);
    end
  end

  // Counts leave from the head of a shift line.
  always_ff @(posedge clk) begin
    if (snap_load) begin
      n_r <= n_active;
      for (int i = 0; i < NUM_STRAINS; i++) begin
        sh_r[i] <= snap[16*i +: 16];
      end
    end else if (out_acc) begin
      for (int i = 0; i < NUM_STRAINS - 1; i++) begin
        sh_r[i] <= sh_r[i+1];
      end
    end
  end

  assign out_ch.valid      = busy_r;
  assign out_ch.mismatches = sh_r[0];
  assign out_ch.slot_out   = 4'(idx_r);
  assign out_ch.last_slot  = is_last;
  assign busy              = busy_r;

endmodule

[rtl/read_vs_strain_mismatch_counter.sv]
// Read-versus-strain mismatch counter. Takes one request per cycle: strain base loads, map
// loads, read starts and read bases. A read base goes through a position-map read at the
// cursor, a column-store read at the mapped column, then a compare of all strains in use at
// once into saturating counters. The final base of a read snapshots the counts, which then
// leave one per cycle while the receiver is ready, one result per strain slot in use, while
// the next read already streams in; only a further final base waits until that emission
// is done. After reset the position map is swept to unmapped, one entry a cycle, during
// which no request is taken; configuration writes are taken at any time.
`include "read_vs_strain_mismatch_counter_assert.svh"

module read_vs_strain_mismatch_counter #(
  parameter int NUM_STRAINS = rsmc_pkg::NUM_STRAINS_DEF,
  parameter int MSA_COLS    = rsmc_pkg::MSA_COLS_DEF,
  parameter int REF_LEN     = rsmc_pkg::REF_LEN_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  rsmc_in_if.sink                   in_ch,
  rsmc_out_if.source                out_ch,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rsmc_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import rsmc_pkg::*;

  localparam int MAP_AW = $clog2(REF_LEN);
  localparam int COL_AW = $clog2(MSA_COLS);
  localparam int N_W    = $clog2(NUM_STRAINS + 1);

  logic [4:0]      strains_r;
  logic [N_W-1:0]  n_active;
  logic [15:0]     cursor_r;
  logic [15:0]     cursor_nxt;
  logic            in_acc;
  logic [2:0]      in_code;
  logic            pos_ok;
  logic            strain_we;
  logic            map_we;
  logic            base_acc;
  logic            clear_busy;
  logic            emit_busy;
  logic            map_valid;
  logic [COL_AW-1:0] map_col;
  logic            hit1;

  logic            p1_base_r;
  logic            p1_start_r;
  logic            p1_last_r;
  logic            p1_ok_r;
  logic [1:0]      p1_code_r;
  rsmc_tally_ctl_t p2_r;
  rsmc_tally_ctl_t p2_nxt;

  logic                      snap_load;
  logic [16*NUM_STRAINS-1:0] snap;
  logic [3*NUM_STRAINS-1:0]  col_data;

  // Configuration
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strains_r <= STRAINS_RESET;
    end else if (psel && penable && pwrite && (paddr[CFG_IDX_LSB] == REG_STRAINS)) begin
      strains_r <= pwdata[4:0];
    end
  end

  assign prdata = (paddr[CFG_IDX_LSB] == REG_STRAINS) ? {27'd0, strains_r} : 32'd0;

  always_comb begin
    if (strains_r == 5'd0) begin
      n_active = N_W'(1);
    end else if (32'(strains_r) > NUM_STRAINS) begin
      n_active = N_W'(NUM_STRAINS);
    end else begin
      n_active = N_W'(strains_r);
    end
  end

  // Request decode
  assign in_ch.ready = !clear_busy &&
                       !((in_ch.action == ACT_BASE) && in_ch.last_base &&
                         (emit_busy || (p1_base_r && p1_last_r) || (p2_r.base && p2_r.last)));
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign in_code   = base_code(in_ch.base_char);
  assign pos_ok    = 32'(cursor_r) < REF_LEN;
  assign base_acc  = in_acc && (in_ch.action == ACT_BASE);
  assign strain_we = in_acc && (in_ch.action == ACT_STRAIN) &&
                     (32'(in_ch.strain_slot) < NUM_STRAINS) && (32'(in_ch.column) < MSA_COLS);
  assign map_we    = in_acc && (in_ch.action == ACT_MAP) &&
                     (32'(in_ch.ref_pos) < REF_LEN) && (32'(in_ch.column) < MSA_COLS);

  always_comb begin
    cursor_nxt = cursor_r;
    if (in_acc && (in_ch.action == ACT_START)) begin
      cursor_nxt = in_ch.read_start - 16'd1;
    end else if (base_acc) begin
      cursor_nxt = cursor_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r   <= '0;
      p1_base_r  <= 1'b0;
      p1_start_r <= 1'b0;
      p2_r       <= '0;
    end else begin
      cursor_r   <= cursor_nxt;
      p1_base_r  <= base_acc;
      p1_start_r <= in_acc && (in_ch.action == ACT_START);
      p2_r       <= p2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p1_last_r <= in_ch.last_base;
    p1_ok_r   <= pos_ok && !in_code[2];
    p1_code_r <= in_code[1:0];
  end

  rsmc_posmap #(
    .REF_LEN  (REF_LEN),
    .MSA_COLS (MSA_COLS),
    .MAP_AW   (MAP_AW),
    .COL_AW   (COL_AW)
  ) u_posmap (
    .clk        (clk),
    .rst_n      (rst_n),
    .we         (map_we),
    .waddr      (MAP_AW'(in_ch.ref_pos)),
    .wcol       (COL_AW'(in_ch.column)),
    .re         (base_acc && pos_ok),
    .raddr      (MAP_AW'(cursor_r)),
    .rd_valid   (map_valid),
    .rd_col     (map_col),
    .clear_busy (clear_busy)
  );

  // Stage 1: mapped column known, fetch the strain bases.
  assign hit1 = p1_base_r && p1_ok_r && map_valid;

  always_comb begin
    p2_nxt.start = p1_start_r;
    p2_nxt.base  = p1_base_r;
    p2_nxt.hit   = hit1;
    p2_nxt.last  = p1_last_r;
    p2_nxt.code  = p1_code_r;
  end

  rsmc_colstore #(
    .NUM_STRAINS (NUM_STRAINS),
    .MSA_COLS    (MSA_COLS),
    .COL_AW      (COL_AW)
  ) u_colstore (
    .clk   (clk),
    .we    (strain_we),
    .waddr (COL_AW'(in_ch.column)),
    .wslot (in_ch.strain_slot),
    .wcode (in_code),
    .re    (hit1),
    .raddr (map_col),
    .rdata (col_data)
  );

  // Stage 2: compare and count.
  rsmc_tally #(
    .NUM_STRAINS (NUM_STRAINS),
    .N_W         (N_W)
  ) u_tally (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (p2_r),
    .col_data  (col_data),
    .n_active  (n_active),
    .snap_load (snap_load),
    .snap      (snap)
  );

  rsmc_emit #(
    .NUM_STRAINS (NUM_STRAINS),
    .N_W         (N_W)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .snap_load (snap_load),
    .snap      (snap),
    .n_active  (n_active),
    .busy      (emit_busy),
    .out_ch    (out_ch)
  );

  `RSMC_ASSERT_IMP(a_one_final_in_flight, 1'b1, $onehot0({p1_base_r && p1_last_r, p2_r.base && p2_r.last, emit_busy}), "more than one final base in flight")
  `RSMC_ASSERT_NXT(a_emit_ends, out_ch.valid && out_ch.ready && out_ch.last_slot, !out_ch.valid, "emission continues past the final slot")
  `RSMC_ASSERT_IMP(a_snap_free, snap_load, !emit_busy, "snapshot lands on a busy emitter")
  `RSMC_ASSERT_IMP(a_quiet_clear, clear_busy, !p1_base_r && !p1_start_r, "request in flight during map clearing")

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import rsmc_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 47;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  strain_slot;
    logic [14:0] column;
    logic [14:0] ref_pos;
    logic [15:0] read_start;
    logic [7:0]  base_char;
    logic        last_base;
  } request_t;

  typedef struct packed {
    logic [3:0]  slot;
    logic [15:0] cnt;
    logic        last;
  } tally_t;

  typedef struct {
    request_t    rq;
    int          typed_n;
    logic [15:0] typed_cnt;
  } drow_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata, prdata;

  rsmc_in_if  in_if();
  rsmc_out_if out_if();

  read_vs_strain_mismatch_counter dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // Predictor state
  logic [47:0] msa_word [int];
  logic [15:0] msa_written [int];
  int          ref_to_col [int];
  logic [15:0] tally [NUM_STRAINS_DEF];
  logic [15:0] cursor;
  logic [4:0]  strains_reg;

  tally_t count_queue [$];
  tally_t fresh_counts [$];
  drow_t  dir_rows [$];

  int   err_count = 0;
  int   cycle_no = 0;
  int   items_sent = 0;
  int   burst_left = 0;
  bit   hold_off_pending = 1'b0;
  int   phase_win;
  logic [14:0] col_pool [6];

  function automatic logic [2:0] char_to_code(input logic [7:0] ch);
    logic [7:0] up;
    up = (ch >= 8'h61 && ch <= 8'h7A) ? ch - 8'h20 : ch;
    if (up == CHAR_A_UP) return CODE_A;
    if (up == CHAR_C_UP) return CODE_C;
    if (up == CHAR_G_UP) return CODE_G;
    if (up == CHAR_T_UP) return CODE_T;
    if (ch == CHAR_GAP) return CODE_GAP;
    return CODE_UNK;
  endfunction

  function automatic int live_strains();
    if (strains_reg == 5'd0) return 1;
    if (int'(strains_reg) > NUM_STRAINS_DEF) return NUM_STRAINS_DEF;
    return int'(strains_reg);
  endfunction

  function automatic bit cursor_mapped();
    return int'(cursor) < REF_LEN_DEF && ref_to_col.exists(int'(cursor));
  endfunction

  // Advance the model by one request; results land in fresh_counts.
  function automatic void tally_request(input request_t r);
    int n;
    logic [2:0] code, sc;
    logic [47:0] word;
    n = live_strains();
    fresh_counts.delete();
    case (r.action)
      ACT_STRAIN: begin
        word = msa_word.exists(int'(r.column)) ? msa_word[int'(r.column)] : '0;
        word[r.strain_slot*3 +: 3] = char_to_code(r.base_char);
        msa_word[int'(r.column)] = word;
        if (!msa_written.exists(int'(r.column))) msa_written[int'(r.column)] = '0;
        msa_written[int'(r.column)][r.strain_slot] = 1'b1;
      end
      ACT_MAP: ref_to_col[int'(r.ref_pos)] = int'(r.column);
      ACT_START: begin
        cursor = r.read_start - 16'd1;
        foreach (tally[i]) tally[i] = '0;
      end
      default: begin
        code = char_to_code(r.base_char);
        if (code <= CODE_T && cursor_mapped()) begin
          word = msa_word[ref_to_col[int'(cursor)]];
          for (int i = 0; i < n; i++) begin
            sc = word[i*3 +: 3];
            if (sc != code && sc != CODE_GAP && tally[i] != COUNT_MAX) tally[i]++;
          end
        end
        cursor = cursor + 16'd1;
        if (r.last_base) begin
          for (int i = 0; i < n; i++)
            fresh_counts.push_back('{4'(i), tally[i], 1'(i == n - 1)});
          foreach (tally[i]) tally[i] = '0;
        end
      end
    endcase
  endfunction

  function automatic void note_error(input string what, input tally_t want, input tally_t got);
    err_count++;
    if (err_count <= 10)
      $display("%0t %s: expected slot %0d count %0d last %0b, got slot %0d count %0d last %0b",
               $realtime, what, want.slot, want.cnt, want.last, got.slot, got.cnt, got.last);
  endfunction

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 11))
      0: return CHAR_A_UP;
      1: return CHAR_C_UP;
      2: return CHAR_G_UP;
      3: return CHAR_T_UP;
      4: return CHAR_A_LO;
      5: return CHAR_C_LO;
      6: return CHAR_G_LO;
      7: return CHAR_T_LO;
      8: return CHAR_GAP;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [14:0] pick_col();
    if ($urandom_range(0, 9) == 0) return 15'($urandom_range(0, 32767));
    return col_pool[$urandom_range(0, 5)];
  endfunction

  function automatic int pick_window();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return REF_LEN_DEF - 16;
      default: return phase_win;
    endcase
  endfunction

  function automatic request_t random_req();
    request_t r;
    r.action      = 2'($urandom_range(0, 3));
    r.strain_slot = 4'($urandom_range(0, 15));
    r.column      = 15'($urandom_range(0, 32767));
    r.ref_pos     = 15'($urandom_range(0, 32767));
    r.read_start  = 16'($urandom_range(0, 65535));
    r.base_char   = 8'($urandom_range(0, 255));
    r.last_base   = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic request_t mk(input logic [1:0] a, input logic [3:0] s,
                                  input logic [14:0] c, input logic [14:0] p,
                                  input logic [15:0] st, input logic [7:0] ch,
                                  input logic lb);
    return '{a, s, c, p, st, ch, lb};
  endfunction

  function automatic void add_row(input request_t q, input int typed_n,
                                  input logic [15:0] typed_cnt);
    dir_rows.push_back('{q, typed_n, typed_cnt});
  endfunction

  task automatic drive_req(input request_t r, input int typed_n, input logic [15:0] typed_cnt);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_if.valid       <= 1'b1;
    in_if.action      <= r.action;
    in_if.strain_slot <= r.strain_slot;
    in_if.column      <= r.column;
    in_if.ref_pos     <= r.ref_pos;
    in_if.read_start  <= r.read_start;
    in_if.base_char   <= r.base_char;
    in_if.last_base   <= r.last_base;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    tally_request(r);
    if (typed_n > 0) begin
      for (int i = 0; i < typed_n; i++)
        count_queue.push_back('{4'(i), typed_cnt, 1'(i == typed_n - 1)});
    end else begin
      foreach (fresh_counts[i]) count_queue.push_back(fresh_counts[i]);
    end
    items_sent++;
  endtask

  // Fill any unwritten live-strain entries of the column a compared base will read.
  task automatic send_req(input request_t r, input int typed_n, input logic [15:0] typed_cnt);
    request_t fill;
    int col;
    if (r.action == ACT_BASE && char_to_code(r.base_char) <= CODE_T && cursor_mapped()) begin
      col = ref_to_col[int'(cursor)];
      for (int s = 0; s < live_strains(); s++) begin
        if (!msa_written.exists(col) || !msa_written[col][s]) begin
          fill = random_req();
          fill.action      = ACT_STRAIN;
          fill.strain_slot = 4'(s);
          fill.column      = 15'(col);
          fill.base_char   = pick_char();
          drive_req(fill, 0, '0);
        end
      end
    end
    drive_req(r, typed_n, typed_cnt);
  endtask

  task automatic send_load(input int base_pos);
    request_t r;
    r = random_req();
    r.action    = $urandom_range(0, 1) ? ACT_STRAIN : ACT_MAP;
    r.column    = pick_col();
    r.ref_pos   = 15'(base_pos + $urandom_range(0, 15));
    r.base_char = pick_char();
    send_req(r, 0, '0);
  endtask

  task automatic run_episode();
    request_t r;
    int kind, base_pos, nb;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      // noise: raw random requests
      repeat ($urandom_range(1, 4)) send_req(random_req(), 0, '0);
    end else begin
      base_pos = pick_window();
      repeat ($urandom_range(0, 4)) send_load(base_pos);
      r = random_req();
      r.action     = ACT_START;
      r.read_start = (kind == 1) ? 16'($urandom_range(0, 65535))
                                 : 16'(base_pos + $urandom_range(1, 8));
      send_req(r, 0, '0);
      nb = $urandom_range(1, 12);
      for (int b = 0; b < nb; b++) begin
        if ($urandom_range(0, 7) == 0) send_load(base_pos);
        r = random_req();
        r.action    = ACT_BASE;
        r.base_char = pick_char();
        // a broken read leaves its last base off and runs into the next one
        r.last_base = (b == nb - 1) && (kind != 2);
        send_req(r, 0, '0);
      end
    end
  endtask

  task automatic cfg_write(input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(REG_STRAINS) << CFG_IDX_LSB;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    strains_reg = v[4:0];
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (count_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [4:0] strains, input bit with_hold);
    int target;
    settle();
    cfg_write(($urandom() & ~32'h1F) | 32'(strains));
    phase_win = $urandom_range(0, REF_LEN_DEF - 64);
    target = items_sent + PHASE_ITEMS;
    if (with_hold) hold_off_pending = 1'b1;
    while (items_sent < target) run_episode();
  endtask

  always @(posedge clk) begin
    tally_t got, want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.slot_out, out_if.mismatches, out_if.last_slot};
      if (count_queue.size() == 0) begin
        note_error("unexpected result", '0, got);
      end else begin
        want = count_queue.pop_front();
        if (want !== got) note_error("mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_no);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result-side back-pressure
  initial begin
    int span, period, duty;
    out_if.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        span = $urandom_range(16, 160);
        if ($urandom_range(0, 3) == 0) begin
          period = 1;
          duty   = 0;
        end else begin
          period = $urandom_range(2, 7);
          duty   = $urandom_range(1, period - 1);
        end
        for (int k = 0; k < span; k++) begin
          out_if.ready <= ((k % period) >= duty);
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    rst_n   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    in_if.valid       = 1'b0;
    in_if.action      = ACT_STRAIN;
    in_if.strain_slot = '0;
    in_if.column      = '0;
    in_if.ref_pos     = '0;
    in_if.read_start  = '0;
    in_if.base_char   = '0;
    in_if.last_base   = 1'b0;

    foreach (tally[i]) tally[i] = '0;
    cursor      = '0;
    strains_reg = STRAINS_RESET;
    col_pool[0] = 15'd0;
    col_pool[1] = 15'h7FFF;
    for (int i = 2; i < 6; i++) col_pool[i] = 15'($urandom_range(1, 32766));

    // after reset: empty map, so every count reads zero
    add_row(mk(ACT_BASE,   4'd0,  15'd0,     15'd0,     16'd0,     CHAR_A_UP, 1'b1), 16, 16'd0);
    add_row(mk(ACT_STRAIN, 4'd0,  15'd0,     15'd0,     16'd0,     CHAR_A_UP, 1'b0), 0, '0);
    add_row(mk(ACT_STRAIN, 4'd1,  15'd0,     15'd0,     16'd0,     CHAR_C_LO, 1'b0), 0, '0);
    add_row(mk(ACT_STRAIN, 4'd2,  15'd0,     15'd0,     16'd0,     CHAR_GAP,  1'b0), 0, '0);
    add_row(mk(ACT_STRAIN, 4'd3,  15'd0,     15'd0,     16'd0,     8'h00,     1'b0), 0, '0);
    add_row(mk(ACT_STRAIN, 4'd15, 15'h7FFF,  15'd0,     16'd0,     CHAR_G_LO, 1'b0), 0, '0);
    add_row(mk(ACT_STRAIN, 4'd0,  15'h7FFF,  15'd0,     16'd0,     8'hFF,     1'b0), 0, '0);
    add_row(mk(ACT_MAP,    4'd0,  15'd0,     15'd0,     16'd0,     8'h00,     1'b0), 0, '0);
    add_row(mk(ACT_MAP,    4'd0,  15'd0,     15'd1,     16'd0,     8'h00,     1'b0), 0, '0);
    add_row(mk(ACT_MAP,    4'd0,  15'h7FFF,  15'h7FFF,  16'd0,     8'h00,     1'b0), 0, '0);
    add_row(mk(ACT_START,  4'd0,  15'd0,     15'd0,     16'd1,     8'h00,     1'b0), 0, '0);
    add_row(mk(ACT_BASE,   4'd0,  15'd0,     15'd0,     16'd0,     CHAR_A_LO, 1'b0), 0, '0);
    add_row(mk(ACT_BASE,   4'd0,  15'd0,     15'd0,     16'd0,     8'hFF,     1'b0), 0, '0);
    add_row(mk(ACT_BASE,   4'd0,  15'd0,     15'd0,     16'd0,     CHAR_G_UP, 1'b0), 0, '0);
    add_row(mk(ACT_BASE,   4'd0,  15'd0,     15'd0,     16'd0,     CHAR_T_UP, 1'b1), 0, '0);
    add_row(mk(ACT_START,  4'd0,  15'd0,     15'd0,     16'h8000,  8'h00,     1'b0), 0, '0);
    add_row(mk(ACT_BASE,   4'd0,  15'd0,     15'd0,     16'd0,     CHAR_C_UP, 1'b0), 0, '0);
    add_row(mk(ACT_BASE,   4'd0,  15'd0,     15'd0,     16'd0,     CHAR_G_LO, 1'b1), 0, '0);
    add_row(mk(ACT_START,  4'd0,  15'd0,     15'd0,     16'd0,     8'h00,     1'b0), 0, '0);
    add_row(mk(ACT_BASE,   4'd0,  15'd0,     15'd0,     16'd0,     CHAR_A_UP, 1'b0), 0, '0);
    add_row(mk(ACT_BASE,   4'd0,  15'd0,     15'd0,     16'd0,     CHAR_T_LO, 1'b1), 0, '0);
    add_row(mk(ACT_START,  4'd0,  15'd0,     15'd0,     16'd2,     8'h00,     1'b0), 0, '0);
    add_row(mk(ACT_STRAIN, 4'd1,  15'd0,     15'd0,     16'd0,     CHAR_T_LO, 1'b0), 0, '0);
    add_row(mk(ACT_BASE,   4'd0,  15'd0,     15'd0,     16'd0,     CHAR_T_UP, 1'b0), 0, '0);
    add_row(mk(ACT_BASE,   4'd0,  15'd0,     15'd0,     16'hFFFF,  CHAR_G_LO, 1'b1), 0, '0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_req(dir_rows[i].rq, dir_rows[i].typed_n, dir_rows[i].typed_cnt);

    run_phase(5'd2, 1'b0);
    run_phase(5'd0, 1'b0);
    run_phase(5'd31, 1'b1);
    run_phase(5'd1, 1'b0);
    run_phase(5'd16, 1'b0);
    run_phase(5'($urandom_range(0, 31)), 1'b0);

    settle();
    if (err_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
